/* sv/alt_pkg.sv */
// Shared types, character codes and field codes for the assembly line tokenizer.
package alt_pkg;

    // Mnemonic letters kept per line (1..8)
    localparam int MAX_CMD = 8;

    localparam int TEXT_W  = 64;
    localparam int LEN_W   = 4;
    localparam int ARG_W   = 32;
    localparam int CHAR_W  = 8;
    localparam int DATA_W  = 104;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_C  = 8'h43;
    localparam logic [7:0] CH_UC_B  = 8'h42;
    localparam logic [7:0] CH_UC_W  = 8'h57;
    localparam logic [7:0] CH_UC_D  = 8'h44;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_W  = 8'h77;
    localparam logic [7:0] CH_LC_D  = 8'h64;

    // Line kinds
    localparam logic [1:0] KIND_INSTR   = 2'd0;
    localparam logic [1:0] KIND_COMMENT = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Data types
    localparam logic [1:0] TYPE_C = 2'd0;
    localparam logic [1:0] TYPE_B = 2'd1;
    localparam logic [1:0] TYPE_W = 2'd2;
    localparam logic [1:0] TYPE_D = 2'd3;

    // Saturation bound of the argument magnitude
    localparam logic [ARG_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [ARG_W-1:0] ARG_MAX   = 32'h7FFF_FFFF;

    // One character request held in the input register
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              eol;
    } alt_char_t;

    // One line result
    typedef struct packed {
        logic [1:0]        kind;
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  length;
        logic              truncated;
        logic              pointer;
        logic [1:0]        dtype;
        logic [ARG_W-1:0]  argument;
    } alt_result_t;

endpackage

/* sv/alt_in_stage.sv */
// Input register for character requests.
module alt_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] char_code
    input  logic                s_tlast,   // end_of_line
    input  logic                advance,
    output logic                char_valid,
    output alt_pkg::alt_char_t  char_out
);

    logic               valid_reg, valid_next;
    alt_pkg::alt_char_t char_reg, char_next;

    // Free when empty or when the held character moves on this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        char_next  = char_reg;
        if (s_tvalid && s_tready) begin
            valid_next    = 1'b1;
            char_next.code = s_tdata;
            char_next.eol  = s_tlast;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        char_reg <= char_next;
    end

    assign char_valid = valid_reg;
    assign char_out   = char_reg;

endmodule

/* sv/alt_parser.sv */
// Per-line parse state and the one-character update that forms the line result.
module alt_parser #(
    parameter int MAX_CMD = alt_pkg::MAX_CMD
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  alt_pkg::alt_char_t    char_in,
    output alt_pkg::alt_result_t  result
);

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_MNEM,
        PH_BLANK1,
        PH_BLANK2,
        PH_BLANK3,
        PH_SIGNED,
        PH_DIGITS,
        PH_DONE,
        PH_COMMENT,
        PH_ERROR
    } phase_t;

    phase_t                         phase_reg, phase_next, ph;
    logic [alt_pkg::TEXT_W-1:0]     text_reg, text_next, text_w;
    logic [alt_pkg::LEN_W-1:0]      count_reg, count_next, count_w;
    logic                           ovf_reg, ovf_next, ovf_w;
    logic                           amp_reg, amp_next, amp_w;
    logic [1:0]                     type_reg, type_next, type_w;
    logic [alt_pkg::ARG_W-1:0]      acc_reg, acc_next, acc_w;
    logic                           neg_reg, neg_next, neg_w;
    logic                           cmt_reg, cmt_next, cmt_w;

    logic [7:0]  c;
    logic        stop;
    logic        is_letter, is_blank, is_space, is_digit;
    logic [35:0] acc_prod;

    assign c         = char_in.code;
    assign is_letter = (c >= alt_pkg::CH_UC_A && c <= alt_pkg::CH_UC_Z) ||
                       (c >= alt_pkg::CH_LC_A && c <= alt_pkg::CH_LC_Z);
    assign is_blank  = (c == alt_pkg::CH_SPACE) || (c == alt_pkg::CH_TAB);
    assign is_space  = (c == alt_pkg::CH_SPACE) ||
                       (c >= alt_pkg::CH_TAB && c <= alt_pkg::CH_CR);
    assign is_digit  = (c >= alt_pkg::CH_ZERO) && (c <= alt_pkg::CH_NINE);

    // acc * 10 + digit; digit codes carry their value in the low nibble
    assign acc_prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                      {32'd0, c[3:0]};

    // Walk the character through the remaining parts of the line
    always_comb begin
        ph      = phase_reg;
        text_w  = text_reg;
        count_w = count_reg;
        ovf_w   = ovf_reg;
        amp_w   = amp_reg;
        type_w  = type_reg;
        acc_w   = acc_reg;
        neg_w   = neg_reg;
        cmt_w   = cmt_reg;
        stop    = 1'b0;

        if (ph == PH_LEAD) begin
            if (is_blank) begin
                stop = 1'b1;
            end else if (c == alt_pkg::CH_SEMI) begin
                cmt_w = 1'b1;
                ph    = PH_COMMENT;
                stop  = 1'b1;
            end else if (!is_letter) begin
                ph   = PH_ERROR;
                stop = 1'b1;
            end else begin
                ph = PH_MNEM;
            end
        end

        if (!stop && ph == PH_MNEM) begin
            if (is_letter) begin
                if (count_w < alt_pkg::LEN_W'(MAX_CMD)) begin
                    for (int i = 0; i < 8; i++) begin
                        if (count_w == alt_pkg::LEN_W'(i)) begin
                            text_w[8*i +: 8] = c;
                        end
                    end
                    count_w = count_w + 1'b1;
                end else begin
                    ovf_w = 1'b1;
                end
                stop = 1'b1;
            end else begin
                ph = PH_BLANK1;
            end
        end

        if (!stop && ph == PH_BLANK1) begin
            if (is_blank) begin
                stop = 1'b1;
            end else begin
                ph = PH_BLANK2;
                if (c == alt_pkg::CH_AMP) begin
                    amp_w = 1'b1;
                    stop  = 1'b1;
                end
            end
        end

        if (!stop && ph == PH_BLANK2) begin
            if (is_blank) begin
                stop = 1'b1;
            end else begin
                ph = PH_BLANK3;
                case (c)
                    alt_pkg::CH_UC_C, alt_pkg::CH_LC_C: begin
                        type_w = alt_pkg::TYPE_C;
                        stop   = 1'b1;
                    end
                    alt_pkg::CH_UC_B, alt_pkg::CH_LC_B: begin
                        type_w = alt_pkg::TYPE_B;
                        stop   = 1'b1;
                    end
                    alt_pkg::CH_UC_W, alt_pkg::CH_LC_W: begin
                        type_w = alt_pkg::TYPE_W;
                        stop   = 1'b1;
                    end
                    alt_pkg::CH_UC_D, alt_pkg::CH_LC_D: begin
                        type_w = alt_pkg::TYPE_D;
                        stop   = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (!stop && ph == PH_BLANK3) begin
            if (is_space) begin
                stop = 1'b1;
            end else if (c == alt_pkg::CH_PLUS || c == alt_pkg::CH_MINUS) begin
                neg_w = (c == alt_pkg::CH_MINUS);
                ph    = PH_SIGNED;
                stop  = 1'b1;
            end else begin
                ph = PH_SIGNED;
            end
        end

        if (!stop && (ph == PH_SIGNED || ph == PH_DIGITS)) begin
            if (is_digit) begin
                acc_w = (acc_prod > {4'd0, alt_pkg::MAG_LIMIT}) ?
                        alt_pkg::MAG_LIMIT : acc_prod[alt_pkg::ARG_W-1:0];
                ph    = PH_DIGITS;
            end else begin
                ph = PH_DONE;
            end
        end
    end

    // Result of the line as it stands after this character
    always_comb begin
        result.kind      = alt_pkg::KIND_INSTR;
        result.text      = text_w;
        result.length    = count_w;
        result.truncated = ovf_w;
        result.pointer   = amp_w;
        result.dtype     = type_w;
        if (neg_w) begin
            result.argument = 32'd0 - acc_w;
        end else begin
            result.argument = (acc_w >= alt_pkg::MAG_LIMIT) ? alt_pkg::ARG_MAX : acc_w;
        end
        if (cmt_w || ph == PH_LEAD || ph == PH_ERROR || count_w == '0) begin
            result.kind      = cmt_w ? alt_pkg::KIND_COMMENT : alt_pkg::KIND_ERROR;
            result.text      = '0;
            result.length    = '0;
            result.truncated = 1'b0;
            result.pointer   = 1'b0;
            result.dtype     = alt_pkg::TYPE_D;
            result.argument  = '0;
        end
    end

    // Commit on each character; the last one of a line clears everything
    always_comb begin
        phase_next = phase_reg;
        text_next  = text_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        amp_next   = amp_reg;
        type_next  = type_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        cmt_next   = cmt_reg;
        if (advance) begin
            if (char_in.eol) begin
                phase_next = PH_LEAD;
                text_next  = '0;
                count_next = '0;
                ovf_next   = 1'b0;
                amp_next   = 1'b0;
                type_next  = alt_pkg::TYPE_D;
                acc_next   = '0;
                neg_next   = 1'b0;
                cmt_next   = 1'b0;
            end else begin
                phase_next = ph;
                text_next  = text_w;
                count_next = count_w;
                ovf_next   = ovf_w;
                amp_next   = amp_w;
                type_next  = type_w;
                acc_next   = acc_w;
                neg_next   = neg_w;
                cmt_next   = cmt_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            text_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            amp_reg   <= 1'b0;
            type_reg  <= alt_pkg::TYPE_D;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            cmt_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            text_reg  <= text_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            amp_reg   <= amp_next;
            type_reg  <= type_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            cmt_reg   <= cmt_next;
        end
    end

endmodule

/* sv/alt_out_stage.sv */
// Result register driving the master-side stream.
module alt_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  alt_pkg::alt_result_t  result,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [103:0]          m_tdata,   // text[63:0] length[67:64] truncated[68]
                                             // pointer[69] data_type[71:70] argument[103:72]
    output logic [1:0]            m_tuser    // line_kind
);

    logic                 valid_reg, valid_next;
    alt_pkg::alt_result_t res_reg, res_next;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load) begin
            valid_next = 1'b1;
            res_next   = result;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {res_reg.argument, res_reg.dtype, res_reg.pointer,
                       res_reg.truncated, res_reg.length, res_reg.text};

endmodule

/* sv/assembly_line_tokenizer.sv */
// Assembly line tokenizer top level: one character per request, one result per line.
// A line's result is loaded into the output register as its last character moves on.
// Throughput: one character per cycle while no finished result waits downstream.
// The input register only holds while a finished result waits downstream.
// Reset (aresetn low, synchronous) empties both registers and restarts the line parse.
module assembly_line_tokenizer #(
    parameter int MAX_CMD = alt_pkg::MAX_CMD
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] char_code
    input  logic          s_tlast,   // end_of_line
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // mnemonic_text[63:0] mnemonic_length[67:64]
                                     // mnemonic_truncated[68] pointer_flag[69]
                                     // data_type[71:70] argument[103:72]
    output logic [1:0]    m_tuser    // line_kind
);

    logic                 char_valid;
    alt_pkg::alt_char_t   char_q;
    alt_pkg::alt_result_t result;
    logic                 advance;
    logic                 load;

    // A character moves on unless it ends a line and the result slot is full and not taken
    assign advance = char_valid && (!char_q.eol || !m_tvalid || m_tready);
    assign load    = advance && char_q.eol;

    alt_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .char_valid (char_valid),
        .char_out   (char_q)
    );

    alt_parser #(
        .MAX_CMD (MAX_CMD)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .char_in (char_q),
        .result  (result)
    );

    alt_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !load)
        else $error("result overwritten while waiting");

    // Input only stalls on a held character
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (char_valid && char_q.eol && m_tvalid && !m_tready))
        else $error("input stalled without cause");

    // Non-instruction lines carry only the default fields
    a_plain_kinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != alt_pkg::KIND_INSTR) |->
        (m_tdata[69:0] == '0 && m_tdata[71:70] == alt_pkg::TYPE_D && m_tdata[103:72] == '0))
        else $error("comment or error line with payload");

    // Instructions keep one to MAX_CMD letters; truncation only at the limit
    a_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == alt_pkg::KIND_INSTR) |->
        (m_tdata[67:64] != '0 && m_tdata[67:64] <= 4'(MAX_CMD) &&
         (!m_tdata[68] || m_tdata[67:64] == 4'(MAX_CMD))))
        else $error("bad mnemonic length");

endmodule

/* test/assembly_line_tokenizer_test.sv */
// Self-checking testbench for the assembly line tokenizer: directed and random lines.
module assembly_line_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int CHAR_TARGET  = 1450;
    localparam int MAX_GAP      = 18;
    localparam int STALL_HOLD   = 250;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_HIGH = 8'hFF;

    // Parse position within the current line
    typedef enum logic [3:0] {
        LP_LEAD, LP_MNEMONIC, LP_AFTER_MNEMONIC, LP_AFTER_AMP, LP_AFTER_TYPE,
        LP_SIGN, LP_DIGITS, LP_DONE, LP_COMMENT, LP_ERROR
    } line_phase_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;

    // Line parser state mirrored by the testbench
    line_phase_t  line_phase;
    logic [63:0]  kept_text;
    int           kept_count;
    bit           text_dropped;
    bit           amp_seen;
    logic [1:0]   type_sel;
    logic [31:0]  magnitude;
    bit           minus_seen;
    bit           comment_line;

    alt_pkg::alt_result_t  expected_lines[$];
    logic [7:0]            line_chars[$];

    int mismatches     = 0;
    int chars_sent     = 0;
    int cycle_count    = 0;
    int sender_max_gap = MAX_GAP;
    int sink_max_gap   = MAX_GAP;
    int sink_hold      = 0;

    string bound_values[4] = '{"2147483647", "2147483648", "2147483649", "4294967296"};
    logic [7:0] type_letters[8] = '{alt_pkg::CH_UC_C, alt_pkg::CH_LC_C,
                                    alt_pkg::CH_UC_B, alt_pkg::CH_LC_B,
                                    alt_pkg::CH_UC_W, alt_pkg::CH_LC_W,
                                    alt_pkg::CH_UC_D, alt_pkg::CH_LC_D};

    assembly_line_tokenizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Line prediction
    // ------------------------------------------------------------------
    function automatic bit is_letter(logic [7:0] c);
        return (c >= alt_pkg::CH_UC_A && c <= alt_pkg::CH_UC_Z) ||
               (c >= alt_pkg::CH_LC_A && c <= alt_pkg::CH_LC_Z);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return (c == alt_pkg::CH_SPACE) || (c == alt_pkg::CH_TAB);
    endfunction

    function automatic void clear_line_state();
        line_phase   = LP_LEAD;
        kept_text    = '0;
        kept_count   = 0;
        text_dropped = 1'b0;
        amp_seen     = 1'b0;
        type_sel     = alt_pkg::TYPE_D;
        magnitude    = '0;
        minus_seen   = 1'b0;
        comment_line = 1'b0;
    endfunction

    // Advance the parse by one character; parts fall through in line order
    function automatic void parse_char(logic [7:0] c);
        longint unsigned prod;
        if (line_phase == LP_LEAD) begin
            if (is_blank(c)) return;
            if (c == alt_pkg::CH_SEMI) begin
                comment_line = 1'b1;
                line_phase   = LP_COMMENT;
                return;
            end
            if (!is_letter(c)) begin
                line_phase = LP_ERROR;
                return;
            end
            line_phase = LP_MNEMONIC;
        end
        if (line_phase == LP_MNEMONIC) begin
            if (is_letter(c)) begin
                if (kept_count < alt_pkg::MAX_CMD) begin
                    kept_text[8*kept_count +: 8] = c;
                    kept_count++;
                end else begin
                    text_dropped = 1'b1;
                end
                return;
            end
            line_phase = LP_AFTER_MNEMONIC;
        end
        if (line_phase == LP_AFTER_MNEMONIC) begin
            if (is_blank(c)) return;
            line_phase = LP_AFTER_AMP;
            if (c == alt_pkg::CH_AMP) begin
                amp_seen = 1'b1;
                return;
            end
        end
        if (line_phase == LP_AFTER_AMP) begin
            if (is_blank(c)) return;
            line_phase = LP_AFTER_TYPE;
            case (c)
                alt_pkg::CH_UC_C, alt_pkg::CH_LC_C: begin
                    type_sel = alt_pkg::TYPE_C;
                    return;
                end
                alt_pkg::CH_UC_B, alt_pkg::CH_LC_B: begin
                    type_sel = alt_pkg::TYPE_B;
                    return;
                end
                alt_pkg::CH_UC_W, alt_pkg::CH_LC_W: begin
                    type_sel = alt_pkg::TYPE_W;
                    return;
                end
                alt_pkg::CH_UC_D, alt_pkg::CH_LC_D: begin
                    type_sel = alt_pkg::TYPE_D;
                    return;
                end
                default: ;
            endcase
        end
        if (line_phase == LP_AFTER_TYPE) begin
            // atoi skips the full whitespace set here
            if (c == alt_pkg::CH_SPACE || (c >= alt_pkg::CH_TAB && c <= alt_pkg::CH_CR))
                return;
            if (c == alt_pkg::CH_PLUS || c == alt_pkg::CH_MINUS) begin
                minus_seen = (c == alt_pkg::CH_MINUS);
                line_phase = LP_SIGN;
                return;
            end
            line_phase = LP_SIGN;
        end
        if (line_phase == LP_SIGN || line_phase == LP_DIGITS) begin
            if (c >= alt_pkg::CH_ZERO && c <= alt_pkg::CH_NINE) begin
                prod = 64'(magnitude) * 10 + 64'(c - alt_pkg::CH_ZERO);
                if (prod > 64'(alt_pkg::MAG_LIMIT)) prod = 64'(alt_pkg::MAG_LIMIT);
                magnitude  = prod[31:0];
                line_phase = LP_DIGITS;
            end else begin
                line_phase = LP_DONE;
            end
        end
    endfunction

    // Predict on every accepted request; the last character yields the line result
    always @(posedge aclk) begin : char_monitor
        alt_pkg::alt_result_t res;
        if (aresetn && s_tvalid && s_tready) begin
            parse_char(s_tdata);
            if (s_tlast) begin
                res       = '0;
                res.dtype = alt_pkg::TYPE_D;
                if (comment_line) begin
                    res.kind = alt_pkg::KIND_COMMENT;
                end else if (line_phase == LP_LEAD || line_phase == LP_ERROR ||
                             kept_count == 0) begin
                    res.kind = alt_pkg::KIND_ERROR;
                end else begin
                    res.kind      = alt_pkg::KIND_INSTR;
                    res.text      = kept_text;
                    res.length    = alt_pkg::LEN_W'(kept_count);
                    res.truncated = text_dropped;
                    res.pointer   = amp_seen;
                    res.dtype     = type_sel;
                    if (minus_seen)
                        res.argument = -magnitude;
                    else
                        res.argument = (magnitude >= alt_pkg::MAG_LIMIT) ?
                                       alt_pkg::ARG_MAX : magnitude;
                end
                expected_lines.push_back(res);
                clear_line_state();
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        alt_pkg::alt_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_lines.size() == 0) begin
                $display("%0t: line result with none expected, actual kind %0d data %h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = expected_lines.pop_front();
                check_field("line_kind", want.kind, m_tuser);
                check_field("mnemonic_text", want.text, m_tdata[63:0]);
                check_field("mnemonic_length", want.length, m_tdata[67:64]);
                check_field("mnemonic_truncated", want.truncated, m_tdata[68]);
                check_field("pointer_flag", want.pointer, m_tdata[69]);
                check_field("data_type", want.dtype, m_tdata[71:70]);
                check_field("argument", want.argument, m_tdata[103:72]);
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stalls, or one long hold when asked for
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end else begin
                stall = $urandom_range(0, sink_max_gap);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offer one character request; called and returns at a falling edge
    task automatic send_char(input logic [7:0] code, input bit eol);
        int gap;
        gap = $urandom_range(0, sender_max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
    endtask

    task automatic push_blanks();
        repeat ($urandom_range(0, 2))
            line_chars.push_back($urandom_range(0, 1) ? alt_pkg::CH_SPACE : alt_pkg::CH_TAB);
    endtask

    task automatic push_noise(input int n);
        repeat (n) line_chars.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_line();
        if (line_chars.size() == 0) line_chars.push_back(alt_pkg::CH_SPACE);
        foreach (line_chars[i]) send_char(line_chars[i], i == line_chars.size() - 1);
        line_chars.delete();
    endtask

    // Mostly well-formed lines with random content, plus comments and noise
    task automatic build_random_line();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            push_blanks();
            line_chars.push_back(alt_pkg::CH_SEMI);
            push_noise($urandom_range(0, 6));
        end else if (pick < 20) begin
            push_noise($urandom_range(1, 8));
        end else begin
            push_blanks();
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
            repeat (n)
                line_chars.push_back(8'(($urandom_range(0, 1) ? alt_pkg::CH_UC_A :
                                         alt_pkg::CH_LC_A) + $urandom_range(0, 25)));
            push_blanks();
            if ($urandom_range(0, 1)) line_chars.push_back(alt_pkg::CH_AMP);
            push_blanks();
            pick = $urandom_range(0, 9);
            if (pick < 6)
                line_chars.push_back(type_letters[$urandom_range(0, 7)]);
            else if (pick < 7)
                line_chars.push_back(8'(alt_pkg::CH_LC_A + $urandom_range(0, 25)));
            // argument whitespace takes the full atoi set
            repeat ($urandom_range(0, 2))
                line_chars.push_back($urandom_range(0, 1) ? alt_pkg::CH_SPACE :
                                     8'($urandom_range(alt_pkg::CH_TAB, alt_pkg::CH_CR)));
            pick = $urandom_range(0, 3);
            if (pick == 0) line_chars.push_back(alt_pkg::CH_MINUS);
            else if (pick == 1) line_chars.push_back(alt_pkg::CH_PLUS);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                repeat ($urandom_range(0, 5))
                    line_chars.push_back(8'(alt_pkg::CH_ZERO + $urandom_range(0, 9)));
            else if (pick < 8)
                repeat ($urandom_range(9, 14))
                    line_chars.push_back(8'(alt_pkg::CH_ZERO + $urandom_range(0, 9)));
            else
                push_text(bound_values[$urandom_range(0, 3)]);
            if ($urandom_range(0, 4) == 0) push_noise($urandom_range(1, 3));
        end
    endtask

    // Stop offering and let every pending line result drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_lines();
        push_text(";");
        send_line();
        // blanks only, then a line opening with a non-letter
        line_chars.push_back(alt_pkg::CH_TAB);
        push_text(" ");
        send_line();
        line_chars.push_back(CH_HASH);
        push_text("x");
        send_line();
        push_text("a");
        send_line();
        // overlong mnemonic, pointer, type B, negative saturation
        push_text("ZzAaYyBbQ&b-2147483649");
        send_line();
        // vertical tab before the sign, positive saturation
        push_text("mov\t & C");
        line_chars.push_back(CH_VT);
        push_text("+2147483648");
        send_line();
        push_text("nop d-");
        send_line();
        push_text("add 7");
        send_line();
        // zero byte ends the string early
        push_text("ld w 12");
        line_chars.push_back(CH_NUL);
        push_text("9");
        send_line();
        push_text("q");
        line_chars.push_back(CH_HIGH);
        send_line();
        wait_idle();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_input_stall();
        sender_max_gap = 0;
        sink_hold      = STALL_HOLD;
        repeat (20) begin
            build_random_line();
            send_line();
        end
        sender_max_gap = MAX_GAP;
        wait_idle();
    endtask

    // Back-to-back stretch with no idling on either side
    task automatic test_no_idle();
        sender_max_gap = 0;
        sink_max_gap   = 0;
        repeat (25) begin
            build_random_line();
            send_line();
        end
        sender_max_gap = MAX_GAP;
        sink_max_gap   = MAX_GAP;
        wait_idle();
    endtask

    task automatic test_random_lines();
        while (chars_sent < CHAR_TARGET) begin
            build_random_line();
            send_line();
        end
        wait_idle();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        clear_line_state();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_lines();
        test_input_stall();
        test_no_idle();
        test_random_lines();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
sv/alt_pkg.sv
sv/alt_in_stage.sv
sv/alt_parser.sv
sv/alt_out_stage.sv
sv/assembly_line_tokenizer.sv
test/assembly_line_tokenizer_test.sv
